// ===== src/lbfe_pkg.sv =====
package lbfe_pkg;

    localparam int NUM_LEDS = 16;
    localparam int IDX_W = $clog2(NUM_LEDS);

    localparam logic [16:0] FULL_LEVEL = 17'd65536;
    localparam logic [16:0] DARK_LIMIT = 17'(3 * 65536 / 8);

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [2:0] EFF_OFF   = 3'd0;
    localparam logic [2:0] EFF_FLASH = 3'd1;
    localparam logic [2:0] EFF_BLINK = 3'd2;
    localparam logic [2:0] EFF_RUN   = 3'd3;
    localparam logic [2:0] EFF_RUNR  = 3'd4;
    localparam logic [2:0] EFF_SCAN  = 3'd5;
    localparam logic [2:0] EFF_SCANR = 3'd6;

    localparam logic [2:0] COL_OFF    = 3'd0;
    localparam logic [2:0] COL_PICKUP = 3'd1;
    localparam logic [2:0] COL_CORE   = 3'd2;
    localparam logic [2:0] COL_BOSS   = 3'd3;
    localparam logic [2:0] COL_HAZARD = 3'd4;

    localparam logic [2:0] REG_FADE   = 3'd0;
    localparam logic [2:0] REG_LIGHT  = 3'd1;
    localparam logic [2:0] REG_PERIOD = 3'd2;
    localparam logic [2:0] REG_DUR    = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic set_en;     // apply a set request
        logic start_en;   // start an effect
        logic eff_en;     // advance effect state (once per tick)
        logic div_start;  // begin flash level divide
        logic led_en;     // update LED at led_idx
        logic [IDX_W-1:0] led_idx;
        logic out_load;   // load output word for led_idx
    } lbfe_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } lbfe_sts_t;

    function automatic logic [3:0] color_base(input logic [2:0] c);
        logic [3:0] b;
        case (c)
            COL_PICKUP: b = 4'd4;
            COL_CORE:   b = 4'd7;
            COL_BOSS:   b = 4'd10;
            COL_HAZARD: b = 4'd1;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/lbfe_ctrl.sv =====
module lbfe_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [1:0] in_action,
    output logic in_ready,
    output lbfe_pkg::lbfe_cmd_t cmd,
    input  lbfe_pkg::lbfe_sts_t sts
);
    import lbfe_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_LED  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic acc;

    assign in_ready = (state_reg == S_IDLE);
    assign acc = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cmd = '0;
        cmd.led_idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    cmd.set_en = (in_action == ACT_SET);
                    cmd.start_en = (in_action == ACT_START);
                    if (in_action == ACT_TICK)
                    begin
                        cmd.div_start = 1'b1;
                        state_next = S_DIV;
                        idx_next = '0;
                    end
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.eff_en = 1'b1;
                    state_next = S_LED;
                end
            end
            S_LED:
            begin
                if (!sts.out_full)
                begin
                    cmd.led_en = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.out_load = 1'b1;
                if (idx_reg == IDX_W'(NUM_LEDS - 1))
                    state_next = S_IDLE;
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_LED;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
        end
    end

`ifndef SYNTH
    a_out_after_led: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.led_en |=> state_reg == S_OUT)
        else $error("led update not followed by output");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready while busy");
    a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eff_en |=> !cmd.eff_en)
        else $error("effect advanced twice");
`endif
endmodule

// ===== src/lbfe_datapath.sv =====
module lbfe_datapath (
    input  logic clk,
    input  logic rst_n,
    input  lbfe_pkg::lbfe_cmd_t cmd,
    output lbfe_pkg::lbfe_sts_t sts,
    input  logic [5:0] led_pos,
    input  logic [2:0] color,
    input  logic [16:0] intensity,
    input  logic [2:0] effect,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [16:0] cfg_data,
    output logic [5:0] out_index,
    output logic [3:0] out_frame,
    output logic out_last,
    output logic out_valid,
    input  logic out_ready
);
    import lbfe_pkg::*;

    logic [16:0] fade_reg, light_reg;
    logic [7:0] period_reg, dur_reg;
    logic [4:0] width_reg;

    logic [2:0] tgt_color_reg [NUM_LEDS];
    logic [16:0] tgt_level_reg [NUM_LEDS];
    logic [2:0] cur_color_reg [NUM_LEDS];
    logic [16:0] cur_level_reg [NUM_LEDS];
    logic [3:0] frame_reg [NUM_LEDS];

    logic [2:0] kind_reg, ecol_reg;
    logic [7:0] timer_reg;
    logic dir_reg;
    logic signed [7:0] pos_reg;

    // Flash level divider: (num << 16) / dur, restoring, one bit per cycle.
    logic [7:0] tim_eff;
    logic signed [9:0] num_s;
    logic flash_lit, flash_sat;
    logic [24:0] quo_reg;
    logic [8:0] rem_reg;
    logic [4:0] dcnt_reg;
    logic div_busy_reg;
    logic [16:0] flash_lvl;

    assign tim_eff = (kind_reg == EFF_BLINK && timer_reg == 8'd0) ? period_reg : timer_reg;
    assign num_s = $signed({2'b0, tim_eff}) - $signed({2'b0, period_reg})
                 + $signed({2'b0, dur_reg});
    assign flash_lit = $signed({2'b0, tim_eff}) >
                       $signed({2'b0, period_reg}) - $signed({2'b0, dur_reg});
    assign flash_sat = (dur_reg == 8'd0) || (num_s > $signed({2'b0, dur_reg}));
    assign flash_lvl = flash_sat ? FULL_LEVEL : quo_reg[16:0];

    logic [9:0] rem_try;
    assign rem_try = {rem_reg, quo_reg[24]} - {2'b0, dur_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg <= 5'd25;
        end
        else if (div_busy_reg)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (dcnt_reg == 5'd1)
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= {num_s[8:0] & {9{!flash_sat}}, 16'd0};
            rem_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            if (!rem_try[9])
            begin
                rem_reg <= rem_try[8:0];
                quo_reg <= {quo_reg[23:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[7:0], quo_reg[24]};
                quo_reg <= {quo_reg[23:0], 1'b0};
            end
        end
    end

    assign sts.div_busy = div_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_reg <= 17'd4096;
            light_reg <= 17'd8192;
            period_reg <= 8'd30;
            dur_reg <= 8'd10;
            width_reg <= 5'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FADE:   fade_reg <= cfg_data;
                REG_LIGHT:  light_reg <= cfg_data;
                REG_PERIOD: period_reg <= cfg_data[7:0];
                REG_DUR:    dur_reg <= cfg_data[7:0];
                REG_WIDTH:  width_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Effect targets per LED.
    logic [2:0] eff_col [NUM_LEDS];
    logic [16:0] eff_lvl [NUM_LEDS];
    logic col_ok;
    assign col_ok = ecol_reg <= COL_HAZARD;

    always_comb
    begin
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            logic hit;
            logic [7:0] d;
            hit = 1'b0;
            d = 8'(i) - 8'(pos_reg);
            if (kind_reg == EFF_RUN || kind_reg == EFF_RUNR)
                hit = 8'(IDX_W'(d)) < {3'b0, width_reg};
            else if (kind_reg == EFF_SCAN || kind_reg == EFF_SCANR)
                hit = $signed(9'(i)) >= 9'(pos_reg) &&
                      $signed(9'(i)) < 9'(pos_reg) + $signed({4'b0, width_reg});
            else if (kind_reg == EFF_FLASH || kind_reg == EFF_BLINK)
                hit = flash_lit && flash_lvl != 17'd0;
            if (hit && col_ok)
            begin
                eff_col[i] = ecol_reg;
                eff_lvl[i] = (kind_reg == EFF_FLASH || kind_reg == EFF_BLINK)
                           ? flash_lvl : FULL_LEVEL;
            end
            else
            begin
                eff_col[i] = COL_OFF;
                eff_lvl[i] = 17'd0;
            end
        end
    end

    logic eff_active;
    assign eff_active = kind_reg != EFF_OFF;

    logic [IDX_W-1:0] sp;
    assign sp = led_pos[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                tgt_color_reg[i] <= '0;
                tgt_level_reg[i] <= '0;
            end
            kind_reg <= EFF_OFF;
            ecol_reg <= '0;
            timer_reg <= '0;
            dir_reg <= 1'b0;
            pos_reg <= '0;
        end
        else if (cmd.set_en)
        begin
            if ({1'b0, led_pos} < 7'(NUM_LEDS) && color <= COL_HAZARD
                && intensity <= FULL_LEVEL
                && color >= tgt_color_reg[sp] && intensity > tgt_level_reg[sp])
            begin
                tgt_color_reg[sp] <= color;
                tgt_level_reg[sp] <= intensity;
            end
        end
        else if (cmd.start_en)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                tgt_color_reg[i] <= '0;
                tgt_level_reg[i] <= '0;
            end
            kind_reg <= (effect > EFF_SCANR) ? EFF_OFF : effect;
            ecol_reg <= color;
            case (effect)
                EFF_FLASH, EFF_BLINK: timer_reg <= period_reg;
                EFF_RUN:
                begin
                    dir_reg <= 1'b0;
                    pos_reg <= '0;
                end
                EFF_RUNR:
                begin
                    dir_reg <= 1'b1;
                    pos_reg <= 8'({1'b0, IDX_W'(8'(NUM_LEDS - 1) - 8'(width_reg))});
                end
                EFF_SCAN:
                begin
                    dir_reg <= 1'b0;
                    pos_reg <= -$signed({3'b0, width_reg});
                end
                EFF_SCANR:
                begin
                    dir_reg <= 1'b1;
                    pos_reg <= 8'(NUM_LEDS);
                end
                default: ;
            endcase
        end
        else if (cmd.eff_en && eff_active)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                tgt_color_reg[i] <= eff_col[i];
                tgt_level_reg[i] <= eff_lvl[i];
            end
            if (kind_reg == EFF_FLASH || kind_reg == EFF_BLINK)
                timer_reg <= (tim_eff != 8'd0) ? tim_eff - 1'b1 : 8'd0;
            else if (kind_reg == EFF_RUN || kind_reg == EFF_RUNR)
                pos_reg <= 8'({1'b0, IDX_W'(pos_reg + (dir_reg ? -8'sd1 : 8'sd1))});
            else
            begin
                logic signed [7:0] np;
                np = pos_reg + (dir_reg ? -8'sd1 : 8'sd1);
                if (np <= -$signed({3'b0, width_reg}))
                begin
                    dir_reg <= ~dir_reg;
                    pos_reg <= -$signed({3'b0, width_reg});
                end
                else if (np >= $signed(8'(NUM_LEDS)))
                begin
                    dir_reg <= ~dir_reg;
                    pos_reg <= 8'(NUM_LEDS);
                end
                else
                    pos_reg <= np;
            end
        end
    end

    // Per-LED fade, one LED per update command.
    logic [IDX_W-1:0] li;
    logic [2:0] cc, tc;
    logic [16:0] cl, tl, nl;
    logic [2:0] ncol;
    logic [17:0] up, dn;
    logic moved;
    logic [3:0] nframe;
    logic [16:0] above;

    assign li = cmd.led_idx;
    assign cc = cur_color_reg[li];
    assign tc = tgt_color_reg[li];
    assign cl = cur_level_reg[li];
    assign tl = tgt_level_reg[li];
    assign up = {1'b0, cl} + {1'b0, light_reg};
    assign dn = {1'b0, cl} - {1'b0, fade_reg};

    always_comb
    begin
        nl = cl;
        ncol = cc;
        moved = 1'b1;
        if (cc != tc)
        begin
            if (dn[17] || dn[16:0] == 17'd0)
            begin
                nl = '0;
                ncol = tc;
            end
            else
                nl = dn[16:0];
        end
        else if (cl < tl)
            nl = (up > {1'b0, tl}) ? tl : up[16:0];
        else if (cl > tl)
            nl = (dn[17] || dn[16:0] < tl) ? tl : dn[16:0];
        else
            moved = 1'b0;
        above = nl - DARK_LIMIT;
        if (nl < DARK_LIMIT || ncol == COL_OFF || ncol > COL_HAZARD)
            nframe = 4'd0;
        else
            nframe = color_base(ncol) + 4'(above[16:14]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                cur_color_reg[i] <= '0;
                cur_level_reg[i] <= '0;
                frame_reg[i] <= '0;
            end
        end
        else if (cmd.led_en && moved)
        begin
            cur_color_reg[li] <= ncol;
            cur_level_reg[li] <= nl;
            frame_reg[li] <= nframe;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index <= 6'(li);
            out_frame <= frame_reg[li];
            out_last <= (li == IDX_W'(NUM_LEDS - 1));
        end
    end

    assign sts.out_full = out_valid && !out_ready;

`ifndef SYNTH
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && !out_ready))
        else $error("output overwritten");
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy_reg)
        else $error("divider did not start");
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.led_en |-> nl <= FULL_LEVEL || cl > FULL_LEVEL)
        else $error("level above full");
`endif
endmodule

// ===== src/led_bar_fade_effect_engine.sv =====
// LED bar fade and effect engine.
// Input stream s_axis: one word per request. tdata packs led_pos, color,
// intensity, effect; tuser carries the action (set, start effect, tick).
// Set and start-effect words give no output.
// A tick word runs the effect step, then walks the 16 LEDs one at a time,
// fading each toward its target, and sends one m_axis word per LED,
// LED 0 first, tlast on the last LED.
// A tick first runs the flash level stage (25 quotient bits, one per cycle,
// then the effect step), then for each LED an update step and then a
// load of the output register. No new input word is accepted until the
// last LED word has been loaded into the output register.
// A stalled sink holds the output word; the LED walk waits for the output
// register to drain and nothing is dropped.
// Reset clears all targets, current levels and frames, stops the effect,
// and loads the register defaults. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at once; the user must make them while idle, which the block does not enforce.
module led_bar_fade_effect_engine (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // led_pos[5:0], color[8:6], intensity[25:9], effect[28:26]
    input  logic [1:0] s_axis_tuser,   // action[1:0]
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [15:0] m_axis_tdata,  // out_index[5:0], out_frame[9:6]
    output logic m_axis_tlast,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [16:0] cfg_data
);
    import lbfe_pkg::*;

    lbfe_cmd_t cmd;
    lbfe_sts_t sts;
    logic [5:0] oi;
    logic [3:0] of;

    lbfe_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_axis_tvalid),
        .in_action(s_axis_tuser),
        .in_ready(s_axis_tready),
        .cmd(cmd),
        .sts(sts)
    );

    lbfe_datapath u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .sts(sts),
        .led_pos(s_axis_tdata[5:0]),
        .color(s_axis_tdata[8:6]),
        .intensity(s_axis_tdata[25:9]),
        .effect(s_axis_tdata[28:26]),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_index(oi),
        .out_frame(of),
        .out_last(m_axis_tlast),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, of, oi};
endmodule
